// ===== src/mecanum_odometry_fusion_unit_assert.svh =====
// Assertion macros shared by the odometry fusion RTL.
`ifndef MECANUM_ODOMETRY_FUSION_UNIT_ASSERT_SVH
`define MECANUM_ODOMETRY_FUSION_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MOFU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mofu assertion failed");

// Next-cycle implication.
`define MOFU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mofu assertion failed");

`endif

// ===== src/mofu_pkg.sv =====
`default_nettype none
package mofu_pkg;

    localparam int NUM_WHEELS = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;
    localparam int DVD_W      = 36;
    localparam int DIV_SHIFT  = 13;

    localparam logic CMD_GYRO = 1'b1;

    localparam logic signed [7:0] WHEEL_INVALID = -8'sd128;

    localparam logic [63:0] K_RATE_Q32 = 64'd540105916;
    localparam logic [63:0] K_VEL_Q32  = 64'd357913906;
    localparam logic [63:0] TICK_Q32   = 64'd171798692;

    localparam logic [33:0] FULL_TURN    = 34'd23592960;
    localparam logic [33:0] QUARTER_TURN = 34'd5898240;
    localparam logic [33:0] FT_X128      = FULL_TURN << 7;
    localparam logic [6:0]  DIV_K        = 7'd45;

    localparam logic [35:0] ONE_Q30 = 36'h0_4000_0000;
    localparam logic [31:0] POLY_C0 = 32'd172273;
    localparam logic [31:0] POLY_C1 = 32'd5026995;
    localparam logic [31:0] POLY_C2 = 32'd85569306;
    localparam logic [31:0] POLY_C3 = 32'd693598668;
    localparam logic [31:0] POLY_C4 = 32'd1686629713;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT      = 2'd0,
        CFG_GYRO_SCALE  = 2'd1,
        CFG_GYRO_PERIOD = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic        start;
        logic        load;
        logic [6:0]  nbits;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] init;
    } t_mul_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > S32_MAX) begin
            res = 32'sh7fff_ffff;
        end else if (v < S32_MIN) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/mofu_smul.sv =====
`default_nettype none
module mofu_smul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mofu_pkg::t_mul_req i_req,
    output mofu_pkg::t_mul_rsp      o_rsp,
    output logic [63:0]             o_acc
);
    import mofu_pkg::*;

    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic [6:0]  r_cnt;
    logic        r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= i_req.nbits;
            end else if (r_cnt != 7'd0) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one multiplier bit per cycle; the top bit of b carries negative weight
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
            if (i_req.load) begin
                r_acc <= i_req.init;
            end
        end else if (r_cnt != 7'd0) begin
            if (r_b[0]) begin
                r_acc <= (r_cnt == 7'd1) ? (r_acc - r_a) : (r_acc + r_a);
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_rsp.busy = (r_cnt != 7'd0);
    assign o_rsp.done = r_done;
    assign o_acc      = r_acc;

endmodule
`default_nettype wire

// ===== src/mecanum_odometry_fusion_unit.sv =====
`default_nettype none
// Channel   Direction  Handshake               Payload
// in        sink       i_in_valid / o_in_stall i_command, wheel counts, i_gyro_raw
// out       source     o_out_valid/ i_out_stall fused heading/rate, position, velocity
// cfg       sink       i_cfg_valid/ o_cfg_ready i_cfg_index, i_cfg_data
//
// One item at a time. The work per item is set by the bit-serial multiplier
// (one multiplier bit per cycle) and, for an odometry item, also by the
// one-bit-per-cycle divide in the sine argument reduction.
// i_rst_n is synchronous, active low; all filter state clears to zero.
// A finished result waits in the output register while the next item is taken;
// the new result is held back until that register is free.
`include "mecanum_odometry_fusion_unit_assert.svh"
module mecanum_odometry_fusion_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_command,
    input  wire logic signed [7:0]                i_wheel_one_raw,
    input  wire logic signed [7:0]                i_wheel_two_raw,
    input  wire logic signed [7:0]                i_wheel_three_raw,
    input  wire logic signed [7:0]                i_wheel_four_raw,
    input  wire logic signed [15:0]               i_gyro_raw,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed [31:0]                    o_fused_heading,
    output logic signed [31:0]                    o_fused_rate,
    output logic signed [31:0]                    o_position_x,
    output logic signed [31:0]                    o_position_y,
    output logic signed [31:0]                    o_velocity_x,
    output logic signed [31:0]                    o_velocity_y,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [mofu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mofu_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mofu_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SETUP = 9'b000000010,
        ST_MUL   = 9'b000000100,
        ST_POST  = 9'b000001000,
        ST_MOD   = 9'b000010000,
        ST_QUAD  = 9'b000100000,
        ST_DIV   = 9'b001000000,
        ST_FOLD  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } t_state;

    typedef enum logic [4:0] {
        STP_G_RATE, STP_G_HEAD,
        STP_O_RATE, STP_O_VX, STP_O_VY, STP_O_HEAD,
        STP_SN_P0, STP_SN_P1, STP_SN_P2, STP_SN_P3, STP_SN_P4, STP_SN_P5,
        STP_TX_A, STP_TX_B, STP_TX_P,
        STP_TY_A, STP_TY_B, STP_TY_P,
        STP_BH_A, STP_BH_B, STP_BR_A, STP_BR_B
    } t_step;

    localparam logic [5:0] MOD_LOAD = 6'd9;
    localparam logic [5:0] MOD_FIX  = 6'd8;

    t_state r_state;
    t_step  r_step;
    logic [5:0] r_cnt;

    // configuration
    logic [8:0]  r_weight;
    logic [24:0] r_gyro_scale;
    logic [24:0] r_gyro_period;

    // filter state
    logic signed [7:0]  r_held [NUM_WHEELS];
    logic signed [31:0] r_odo_head;
    logic signed [31:0] r_odo_rate;
    logic signed [31:0] r_gyro_head;
    logic signed [31:0] r_gyro_rate;
    logic signed [31:0] r_pos_x;
    logic signed [31:0] r_pos_y;
    logic signed [31:0] r_vel_x;
    logic signed [31:0] r_vel_y;
    logic signed [31:0] r_fused_head;
    logic signed [31:0] r_fused_rate;

    // per-item working registers
    logic signed [11:0] r_srate;
    logic signed [11:0] r_svx;
    logic signed [11:0] r_svy;
    logic signed [15:0] r_graw;
    logic [8:0]         r_wt;
    logic               r_cos_pass;
    logic [33:0]        r_rem;
    logic [1:0]         r_quad;
    logic [DVD_W-1:0]   r_dvd;
    logic [5:0]         r_drem;
    logic [DVD_W-1:0]   r_t;
    logic [31:0]        r_t2;
    logic [31:0]        r_p;
    logic signed [31:0] r_sin;
    logic signed [31:0] r_cos;
    logic signed [31:0] r_tx;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_o_head;
    logic signed [31:0] r_o_rate;
    logic signed [31:0] r_o_px;
    logic signed [31:0] r_o_py;
    logic signed [31:0] r_o_vx;
    logic signed [31:0] r_o_vy;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    logic [63:0] mul_acc;

    mofu_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp),
        .o_acc   (mul_acc)
    );

    // wheel selection and mecanum sums
    logic signed [7:0]  wheel_raw [NUM_WHEELS];
    logic signed [7:0]  wheel_eff [NUM_WHEELS];
    logic signed [11:0] wheel_sgn [NUM_WHEELS];
    logic signed [11:0] sum_rate;
    logic signed [11:0] sum_vx;
    logic signed [11:0] sum_vy;

    assign wheel_raw[0] = i_wheel_one_raw;
    assign wheel_raw[1] = i_wheel_two_raw;
    assign wheel_raw[2] = i_wheel_three_raw;
    assign wheel_raw[3] = i_wheel_four_raw;

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            wheel_eff[i] = (wheel_raw[i] == WHEEL_INVALID) ? r_held[i] : wheel_raw[i];
            // wheels two and four turn the other way
            wheel_sgn[i] = (i % 2 == 1) ? -12'(wheel_eff[i]) : 12'(wheel_eff[i]);
        end
        sum_rate = -wheel_sgn[0] + wheel_sgn[1] - wheel_sgn[2] + wheel_sgn[3];
        sum_vx   =  wheel_sgn[0] + wheel_sgn[1] + wheel_sgn[2] + wheel_sgn[3];
        sum_vy   = -wheel_sgn[0] + wheel_sgn[1] + wheel_sgn[2] - wheel_sgn[3];
    end

    logic signed [63:0] acc_s;
    logic signed [63:0] acc_r8;
    logic signed [63:0] acc_r16;
    logic signed [63:0] acc_r24;
    logic signed [63:0] acc_r30;
    logic signed [63:0] acc_r32;
    logic signed [31:0] sine_val;

    assign acc_s    = $signed(mul_acc);
    assign acc_r8   = acc_s >>> 8;
    assign acc_r16  = acc_s >>> 16;
    assign acc_r24  = acc_s >>> 24;
    assign acc_r30  = acc_s >>> 30;
    assign acc_r32  = acc_s >>> 32;
    assign sine_val = acc_r30[31:0];

    logic [33:0] ft_shift;
    logic [33:0] mod_angle;
    logic [1:0]  quad_sel;
    logic [33:0] quad_base;
    logic [6:0]  div_try;
    logic        div_ge;
    logic [9:0]  wt_inv;

    assign ft_shift  = FULL_TURN << r_cnt[2:0];
    assign mod_angle = 34'(r_odo_head) + (r_cos_pass ? QUARTER_TURN : 34'd0);
    assign div_try   = {r_drem, r_dvd[DVD_W-1]};
    assign div_ge    = (div_try >= DIV_K);
    assign wt_inv    = 10'd256 - 10'(r_wt);

    always_comb begin
        if (r_rem >= 34'(3) * QUARTER_TURN) begin
            quad_sel  = 2'd3;
            quad_base = 34'(3) * QUARTER_TURN;
        end else if (r_rem >= 34'(2) * QUARTER_TURN) begin
            quad_sel  = 2'd2;
            quad_base = 34'(2) * QUARTER_TURN;
        end else if (r_rem >= QUARTER_TURN) begin
            quad_sel  = 2'd1;
            quad_base = QUARTER_TURN;
        end else begin
            quad_sel  = 2'd0;
            quad_base = 34'd0;
        end
    end

    // serial multiplier operands; init is the rounding half, zero for sine steps
    always_comb begin
        mul_req       = '0;
        mul_req.start = (r_state == ST_SETUP);
        mul_req.load  = 1'b1;
        mul_req.nbits = 7'd32;
        case (r_step)
            STP_G_RATE: begin
                mul_req.a     = 64'(r_gyro_scale);
                mul_req.b     = 64'(r_graw);
                mul_req.nbits = 7'd16;
                mul_req.init  = 64'd1 << 7;
            end
            STP_G_HEAD: begin
                mul_req.a    = 64'(r_gyro_period);
                mul_req.b    = 64'(r_gyro_rate);
                mul_req.init = 64'd1 << 23;
            end
            STP_O_RATE: begin
                mul_req.a     = K_RATE_Q32;
                mul_req.b     = 64'(r_srate);
                mul_req.nbits = 7'd12;
                mul_req.init  = 64'd1 << 15;
            end
            STP_O_VX: begin
                mul_req.a     = K_VEL_Q32;
                mul_req.b     = 64'(r_svx);
                mul_req.nbits = 7'd12;
                mul_req.init  = 64'd1 << 15;
            end
            STP_O_VY: begin
                mul_req.a     = K_VEL_Q32;
                mul_req.b     = 64'(r_svy);
                mul_req.nbits = 7'd12;
                mul_req.init  = 64'd1 << 15;
            end
            STP_O_HEAD: begin
                mul_req.a    = TICK_Q32;
                mul_req.b    = 64'(r_odo_rate);
                mul_req.init = 64'd1 << 31;
            end
            STP_SN_P0: begin
                mul_req.a = 64'(r_t[30:0]);
                mul_req.b = 64'(r_t[30:0]);
            end
            STP_SN_P1: begin
                mul_req.a = 64'(r_t2);
                mul_req.b = 64'(POLY_C0);
            end
            STP_SN_P2, STP_SN_P3, STP_SN_P4: begin
                mul_req.a = 64'(r_t2);
                mul_req.b = 64'(r_p);
            end
            STP_SN_P5: begin
                mul_req.a = 64'(r_t[30:0]);
                mul_req.b = 64'(r_p);
            end
            STP_TX_A: begin
                mul_req.a    = 64'(r_vel_x);
                mul_req.b    = 64'(r_cos);
                mul_req.init = 64'd1 << 29;
            end
            STP_TX_B: begin
                mul_req.a    = 64'(r_vel_y);
                mul_req.b    = 64'(r_sin);
                mul_req.load = 1'b0;
            end
            STP_TX_P, STP_TY_P: begin
                mul_req.a    = TICK_Q32;
                mul_req.b    = 64'(r_tx);
                mul_req.init = 64'd1 << 31;
            end
            STP_TY_A: begin
                mul_req.a    = 64'(r_vel_y);
                mul_req.b    = 64'(r_cos);
                mul_req.init = 64'd1 << 29;
            end
            STP_TY_B: begin
                mul_req.a    = 64'(r_vel_x);
                mul_req.b    = 64'(r_sin);
                mul_req.load = 1'b0;
            end
            STP_BH_A: begin
                mul_req.a     = 64'(r_gyro_head);
                mul_req.b     = 64'(r_wt);
                mul_req.nbits = 7'd10;
                mul_req.init  = 64'd1 << 7;
            end
            STP_BH_B: begin
                mul_req.a     = 64'(r_odo_head);
                mul_req.b     = 64'(wt_inv);
                mul_req.nbits = 7'd10;
                mul_req.load  = 1'b0;
            end
            STP_BR_A: begin
                mul_req.a     = 64'(r_gyro_rate);
                mul_req.b     = 64'(r_wt);
                mul_req.nbits = 7'd10;
                mul_req.init  = 64'd1 << 7;
            end
            STP_BR_B: begin
                mul_req.a     = 64'(r_odo_rate);
                mul_req.b     = 64'(wt_inv);
                mul_req.nbits = 7'd10;
                mul_req.load  = 1'b0;
            end
            default: begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight      <= 9'd205;
            r_gyro_scale  <= 25'd128000;
            r_gyro_period <= 25'd83886;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WEIGHT:      r_weight      <= i_cfg_data[8:0];
                CFG_GYRO_SCALE:  r_gyro_scale  <= i_cfg_data;
                CFG_GYRO_PERIOD: r_gyro_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= STP_G_RATE;
            r_cnt        <= '0;
            r_cos_pass   <= 1'b0;
            r_wt         <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NUM_WHEELS; i++) begin
                r_held[i] <= '0;
            end
            r_odo_head   <= '0;
            r_odo_rate   <= '0;
            r_gyro_head  <= '0;
            r_gyro_rate  <= '0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_vel_x      <= '0;
            r_vel_y      <= '0;
            r_fused_head <= '0;
            r_fused_rate <= '0;
        end else begin
            // a reload in ST_OUT takes precedence over the drain
            if (r_out_valid && !i_out_stall && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        if (i_command == CMD_GYRO) begin
                            r_step <= STP_G_RATE;
                        end else begin
                            r_step <= STP_O_RATE;
                            for (int i = 0; i < NUM_WHEELS; i++) begin
                                if (wheel_raw[i] != WHEEL_INVALID) begin
                                    r_held[i] <= wheel_raw[i];
                                end
                            end
                        end
                        r_srate    <= sum_rate;
                        r_svx      <= sum_vx;
                        r_svy      <= sum_vy;
                        r_graw     <= i_gyro_raw;
                        r_wt       <= (r_weight > 9'd256) ? 9'd256 : r_weight;
                        r_cos_pass <= 1'b0;
                        r_state    <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    if (mul_rsp.done) begin
                        r_state <= ST_POST;
                    end
                end
                ST_POST: begin
                    case (r_step)
                        STP_G_RATE: begin
                            r_gyro_rate <= sat32(acc_r8);
                            r_step      <= STP_G_HEAD;
                            r_state     <= ST_SETUP;
                        end
                        STP_G_HEAD: begin
                            r_gyro_head <= sat32(64'(r_gyro_head) + acc_r24);
                            r_state     <= ST_OUT;
                        end
                        STP_O_RATE: begin
                            r_odo_rate <= sat32(acc_r16);
                            r_step     <= STP_O_VX;
                            r_state    <= ST_SETUP;
                        end
                        STP_O_VX: begin
                            r_vel_x <= sat32(acc_r16);
                            r_step  <= STP_O_VY;
                            r_state <= ST_SETUP;
                        end
                        STP_O_VY: begin
                            r_vel_y <= sat32(acc_r16);
                            r_step  <= STP_O_HEAD;
                            r_state <= ST_SETUP;
                        end
                        STP_O_HEAD: begin
                            r_odo_head <= sat32(64'(r_odo_head) + acc_r32);
                            r_cnt      <= MOD_LOAD;
                            r_state    <= ST_MOD;
                        end
                        STP_SN_P0: begin
                            r_t2    <= acc_r30[31:0];
                            r_step  <= STP_SN_P1;
                            r_state <= ST_SETUP;
                        end
                        STP_SN_P1: begin
                            r_p     <= 32'(64'(POLY_C1) - acc_r30);
                            r_step  <= STP_SN_P2;
                            r_state <= ST_SETUP;
                        end
                        STP_SN_P2: begin
                            r_p     <= 32'(64'(POLY_C2) - acc_r30);
                            r_step  <= STP_SN_P3;
                            r_state <= ST_SETUP;
                        end
                        STP_SN_P3: begin
                            r_p     <= 32'(64'(POLY_C3) - acc_r30);
                            r_step  <= STP_SN_P4;
                            r_state <= ST_SETUP;
                        end
                        STP_SN_P4: begin
                            r_p     <= 32'(64'(POLY_C4) - acc_r30);
                            r_step  <= STP_SN_P5;
                            r_state <= ST_SETUP;
                        end
                        STP_SN_P5: begin
                            if (!r_cos_pass) begin
                                r_sin      <= r_quad[1] ? -sine_val : sine_val;
                                r_cos_pass <= 1'b1;
                                r_cnt      <= MOD_LOAD;
                                r_state    <= ST_MOD;
                            end else begin
                                r_cos   <= r_quad[1] ? -sine_val : sine_val;
                                r_step  <= STP_TX_A;
                                r_state <= ST_SETUP;
                            end
                        end
                        STP_TX_A: begin
                            r_step  <= STP_TX_B;
                            r_state <= ST_SETUP;
                        end
                        STP_TX_B: begin
                            r_tx    <= acc_r30[31:0];
                            r_step  <= STP_TX_P;
                            r_state <= ST_SETUP;
                        end
                        STP_TX_P: begin
                            r_pos_x <= sat32(64'(r_pos_x) + acc_r32);
                            r_step  <= STP_TY_A;
                            r_state <= ST_SETUP;
                        end
                        STP_TY_A: begin
                            r_step  <= STP_TY_B;
                            r_state <= ST_SETUP;
                        end
                        STP_TY_B: begin
                            r_tx    <= acc_r30[31:0];
                            r_step  <= STP_TY_P;
                            r_state <= ST_SETUP;
                        end
                        STP_TY_P: begin
                            r_pos_y <= sat32(64'(r_pos_y) + acc_r32);
                            r_step  <= STP_BH_A;
                            r_state <= ST_SETUP;
                        end
                        STP_BH_A: begin
                            r_step  <= STP_BH_B;
                            r_state <= ST_SETUP;
                        end
                        STP_BH_B: begin
                            r_fused_head <= sat32(acc_r8);
                            r_step       <= STP_BR_A;
                            r_state      <= ST_SETUP;
                        end
                        STP_BR_A: begin
                            r_step  <= STP_BR_B;
                            r_state <= ST_SETUP;
                        end
                        STP_BR_B: begin
                            r_fused_rate <= sat32(acc_r8);
                            r_state      <= ST_OUT;
                        end
                        default: r_state <= ST_IDLE;
                    endcase
                end
                ST_MOD: begin
                    // load, fold negatives up, then strip multiples of a full turn
                    if (r_cnt == MOD_LOAD) begin
                        r_rem <= mod_angle;
                    end else if (r_cnt == MOD_FIX) begin
                        if (r_rem[33]) begin
                            r_rem <= r_rem + FT_X128;
                        end
                    end else if (r_rem >= ft_shift) begin
                        r_rem <= r_rem - ft_shift;
                    end
                    if (r_cnt == 6'd0) begin
                        r_state <= ST_QUAD;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                ST_QUAD: begin
                    r_quad  <= quad_sel;
                    r_dvd   <= 36'(r_rem - quad_base) << DIV_SHIFT;
                    r_drem  <= '0;
                    r_t     <= '0;
                    r_cnt   <= 6'(DVD_W);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_drem <= div_ge ? 6'(div_try - DIV_K) : div_try[5:0];
                    r_t    <= {r_t[DVD_W-2:0], div_ge};
                    r_dvd  <= r_dvd << 1;
                    r_cnt  <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_state <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    if (r_quad[0]) begin
                        r_t <= ONE_Q30 - r_t;
                    end
                    r_step  <= STP_SN_P0;
                    r_state <= ST_SETUP;
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_head    <= r_fused_head;
                        r_o_rate    <= r_fused_rate;
                        r_o_px      <= r_pos_x;
                        r_o_py      <= r_pos_y;
                        r_o_vx      <= r_vel_x;
                        r_o_vy      <= r_vel_y;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_fused_heading = r_o_head;
    assign o_fused_rate    = r_o_rate;
    assign o_position_x    = r_o_px;
    assign o_position_y    = r_o_py;
    assign o_velocity_x    = r_o_vx;
    assign o_velocity_y    = r_o_vy;

    `MOFU_ASSERT_NEXT(a_out_load, (r_state == ST_OUT) && out_free, o_out_valid && (r_state == ST_IDLE))
    `MOFU_ASSERT_IMPL(a_mul_done_in_wait, mul_rsp.done, r_state == ST_MUL)
    `MOFU_ASSERT_IMPL(a_post_mul_idle, r_state == ST_POST, !mul_rsp.busy)
    `MOFU_ASSERT_IMPL(a_mod_in_range, r_state == ST_QUAD, r_rem < FULL_TURN)
    `MOFU_ASSERT_IMPL(a_weight_clamped, r_state != ST_IDLE, r_wt <= 9'd256)

endmodule
`default_nettype wire
